// ===== hdl/brm_pkg.sv =====
// ----------------------------------------------------------------------------
// brm_pkg
// Shared types and constants for the button repeat adjuster and map lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package brm_pkg;

  localparam int MapRows  = 4;
  localparam int MapCols  = 10;
  localparam int RowSpan  = 10;

  typedef logic [11:0] value_t;
  typedef logic [8:0]  map_t;

  typedef enum logic [2:0] {
    REG_REPEAT_DELAY = 3'd0,
    REG_FAST_PERIOD  = 3'd1,
    REG_FAST_STEP    = 3'd2,
    REG_SPEED_MIN    = 3'd3,
    REG_SPEED_MAX    = 3'd4,
    REG_THROTTLE_MIN = 3'd5,
    REG_THROTTLE_MAX = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] repeat_delay;
    logic [31:0] fast_period;
    logic [11:0] fast_step;
  } repeat_cfg_t;

  // step size and hold period are shared by both buttons
  typedef struct packed {
    value_t      value;
    logic [11:0] step_size;
    logic [31:0] hold_period;
  } btn_shared_t;

  typedef struct packed {
    logic        held;
    logic [31:0] deadline;
  } btn_state_t;

  localparam map_t MAP_ROM [MapRows][MapCols] = '{
    '{9'd280, 9'd280, 9'd280, 9'd272, 9'd290, 9'd300, 9'd300, 9'd300, 9'd300, 9'd300},
    '{9'd280, 9'd280, 9'd280, 9'd312, 9'd332, 9'd342, 9'd342, 9'd342, 9'd282, 9'd282},
    '{9'd280, 9'd280, 9'd330, 9'd415, 9'd415, 9'd427, 9'd437, 9'd437, 9'd322, 9'd322},
    '{9'd287, 9'd300, 9'd322, 9'd357, 9'd370, 9'd370, 9'd437, 9'd460, 9'd322, 9'd322}
  };

  // lowest speed at which (418*r - 4*r*r)/1000, r = speed/100, reaches column k+1
  localparam value_t COL_SPEED_START [MapCols-1] = '{
    12'd300, 12'd600, 12'd800, 12'd1100, 12'd1400,
    12'd1800, 12'd2100, 12'd2600, 12'd3100
  };

endpackage

`default_nettype wire

// ===== hdl/brm_button.sv =====
// ----------------------------------------------------------------------------
// brm_button
// One button's press, release and auto-repeat handling for a single poll.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_button (
  input  wire logic                 pressed,
  input  wire logic                 is_down,
  input  wire brm_pkg::value_t      lo,
  input  wire brm_pkg::value_t      hi,
  input  wire logic [31:0]          now,
  input  wire brm_pkg::repeat_cfg_t cfg,
  input  wire brm_pkg::btn_state_t  state_in,
  input  wire brm_pkg::btn_shared_t shared_in,
  output brm_pkg::btn_state_t       state_out,
  output brm_pkg::btn_shared_t      shared_out
);

  logic [12:0]     sum;
  brm_pkg::value_t diff;
  brm_pkg::value_t stepped;
  logic [31:0]     deadline_new;

  always_comb begin
    sum  = {1'b0, shared_in.value} + {1'b0, shared_in.step_size};
    diff = shared_in.value - shared_in.step_size;
    if (!is_down) begin
      if (sum > {1'b0, hi}) begin
        stepped = hi;
      end else begin
        stepped = sum[11:0];
      end
    end else begin
      if (shared_in.step_size > shared_in.value) begin
        stepped = lo;
      end else if (diff < lo || diff > hi) begin
        stepped = lo;
      end else begin
        stepped = diff;
      end
    end
  end

  always_comb begin
    state_out    = state_in;
    shared_out   = shared_in;
    deadline_new = state_in.deadline;
    // new press
    if (pressed && !state_in.held) begin
      deadline_new         = now + shared_in.hold_period;
      state_out.held       = 1'b1;
      state_out.deadline   = deadline_new;
      shared_out.value     = stepped;
      shared_out.step_size = 12'd1;
    end
    // release
    if (!pressed && state_in.held) begin
      state_out.held         = 1'b0;
      shared_out.hold_period = cfg.repeat_delay;
    end
    // held past deadline
    if (pressed && now > deadline_new) begin
      state_out.held         = 1'b0;
      shared_out.step_size   = cfg.fast_step;
      shared_out.hold_period = cfg.fast_period;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/brm_map.sv =====
// ----------------------------------------------------------------------------
// brm_map
// Map lookup: throttle picks the row, a speed band picks the column.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_map (
  input  wire brm_pkg::value_t speed,
  input  wire logic [5:0]      throttle,
  output brm_pkg::map_t        map_value
);

  logic [1:0] row;
  logic [3:0] col;

  always_comb begin
    priority if (throttle >= 6'(3 * brm_pkg::RowSpan)) begin
      row = 2'd3;
    end else if (throttle >= 6'(2 * brm_pkg::RowSpan)) begin
      row = 2'd2;
    end else if (throttle >= 6'(brm_pkg::RowSpan)) begin
      row = 2'd1;
    end else begin
      row = 2'd0;
    end
  end

  // thresholds rise, so the last one passed wins; saturates at the last column
  always_comb begin
    col = 4'd0;
    for (int k = 0; k < brm_pkg::MapCols - 1; k++) begin
      if (speed >= brm_pkg::COL_SPEED_START[k]) begin
        col = 4'(k + 1);
      end
    end
  end

  assign map_value = brm_pkg::MAP_ROM[row][col];

endmodule

`default_nettype wire

// ===== hdl/button_repeat_adjust_map_lookup_top.sv =====
// ----------------------------------------------------------------------------
// button_repeat_adjust_map_lookup_top
// Two-button speed/throttle adjuster with auto-repeat and map table lookup.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle unless stalled. The button logic, clamps
// and map lookup run in a single pass between the input ports and the result
// register, so the result of an item appears in the cycle after it is accepted
// and the adjusted values are updated at that same edge. in_stall rises only
// while a result is waiting in the result register and out_stall holds it there.
// The register port never stalls; write it only while no item is in flight.
`default_nettype none

module button_repeat_adjust_map_lookup_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        up_pressed,
  input  wire logic        down_pressed,
  input  wire logic        edit_speed,
  input  wire logic [31:0] now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      speed_value,
  output logic [5:0]       throttle_value,
  output logic [8:0]       map_value
);

  brm_pkg::repeat_cfg_t rcfg;
  brm_pkg::value_t      speed_min;
  brm_pkg::value_t      speed_max;
  logic [5:0]           throttle_min;
  logic [5:0]           throttle_max;

  brm_pkg::value_t      speed;
  logic [5:0]           throttle;
  brm_pkg::btn_shared_t shared;
  brm_pkg::btn_state_t  up_state;
  brm_pkg::btn_state_t  down_state;

  brm_pkg::btn_shared_t shared_start;
  brm_pkg::btn_shared_t shared_mid;
  brm_pkg::btn_shared_t shared_next;
  brm_pkg::btn_state_t  up_state_next;
  brm_pkg::btn_state_t  down_state_next;
  brm_pkg::value_t      lo;
  brm_pkg::value_t      hi;
  brm_pkg::value_t      speed_next;
  logic [5:0]           throttle_next;
  brm_pkg::map_t        map_next;
  logic                 accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rcfg.repeat_delay <= 32'd10000;
      rcfg.fast_period  <= 32'd100;
      rcfg.fast_step    <= 12'd100;
      speed_min         <= 12'd500;
      speed_max         <= 12'd4000;
      throttle_min      <= 6'd0;
      throttle_max      <= 6'd30;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        brm_pkg::REG_REPEAT_DELAY: rcfg.repeat_delay <= cfg_data;
        brm_pkg::REG_FAST_PERIOD:  rcfg.fast_period  <= cfg_data;
        brm_pkg::REG_FAST_STEP:    rcfg.fast_step    <= cfg_data[11:0];
        brm_pkg::REG_SPEED_MIN:    speed_min         <= cfg_data[11:0];
        brm_pkg::REG_SPEED_MAX:    speed_max         <= cfg_data[11:0];
        brm_pkg::REG_THROTTLE_MIN: throttle_min      <= cfg_data[5:0];
        brm_pkg::REG_THROTTLE_MAX: throttle_max      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shared_start             = shared;
    shared_start.value       = edit_speed ? speed : {6'd0, throttle};
    lo                       = edit_speed ? speed_min : {6'd0, throttle_min};
    hi                       = edit_speed ? speed_max : {6'd0, throttle_max};
  end

  brm_button u_up (
    .pressed    (up_pressed),
    .is_down    (1'b0),
    .lo         (lo),
    .hi         (hi),
    .now        (now),
    .cfg        (rcfg),
    .state_in   (up_state),
    .shared_in  (shared_start),
    .state_out  (up_state_next),
    .shared_out (shared_mid)
  );

  brm_button u_down (
    .pressed    (down_pressed),
    .is_down    (1'b1),
    .lo         (lo),
    .hi         (hi),
    .now        (now),
    .cfg        (rcfg),
    .state_in   (down_state),
    .shared_in  (shared_mid),
    .state_out  (down_state_next),
    .shared_out (shared_next)
  );

  assign speed_next    = edit_speed ? shared_next.value : speed;
  assign throttle_next = edit_speed ? throttle : shared_next.value[5:0];

  brm_map u_map (
    .speed     (speed_next),
    .throttle  (throttle_next),
    .map_value (map_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      speed              <= 12'd500;
      throttle           <= 6'd0;
      shared.value       <= 12'd0;
      shared.step_size   <= 12'd1;
      shared.hold_period <= 32'd10000;
      up_state.held      <= 1'b1;
      up_state.deadline  <= 32'd0;
      down_state.held    <= 1'b0;
      down_state.deadline <= 32'd0;
    end else if (accept) begin
      speed              <= speed_next;
      throttle           <= throttle_next;
      shared.value       <= 12'd0;
      shared.step_size   <= shared_next.step_size;
      shared.hold_period <= shared_next.hold_period;
      up_state           <= up_state_next;
      down_state         <= down_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      speed_value    <= speed_next;
      throttle_value <= throttle_next;
      map_value      <= map_next;
    end
  end

  // an accepted item always leaves a result behind
  assert property (@(posedge clk) disable iff (rst) accept |=> out_valid)
    else $error("accepted item left no result");

  // result register tracks the stored settings
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_value == speed && throttle_value == throttle))
    else $error("result does not match stored settings");

  // every map entry lies in the table's range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (map_value >= 9'd272 && map_value <= 9'd460))
    else $error("map value outside table range");

  // settings only move when an item is taken
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(speed) && $stable(throttle)))
    else $error("settings changed without an item");

endmodule

`default_nettype wire
